// ===== hw/rtl/axli_pkg.sv =====
// axli_pkg: shared constants, codes and types of the axelrod link interaction block
// no dependencies; imported by the interfaces and every module of the block

package axli_pkg;

    localparam int AXLI_SIDE       = 32;
    localparam int AXLI_TRAITS     = 10;
    localparam int AXLI_VALUE_BITS = 3;

    localparam int WORD_BITS  = 30;
    localparam int NODE_BITS  = 10;
    localparam int DRAW_BITS  = 16;
    localparam int SIM_BITS   = 4;
    localparam int TRAIT_BITS = 4;

    typedef enum logic [1:0] {
        FUNC_WRITE,
        FUNC_READ,
        FUNC_LINK
    } axli_func_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_NBR,
        S_RD_DST,
        S_RD_SRC,
        S_LOAD,
        S_COUNT,
        S_DECIDE,
        S_SELECT,
        S_DONE
    } axli_state_t;

    typedef struct packed {
        logic                 same;
        logic [WORD_BITS-1:0] merged;
    } axli_cmp_t;

endpackage

// ===== hw/rtl/axli_if.sv =====
// axli_req_if and axli_rsp_if: valid/ready channels of the link interaction block
// depends on axli_pkg for the payload widths

interface axli_req_if
    import axli_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           func;
    logic [NODE_BITS-1:0] node;
    logic                 vertical_link;
    logic                 neighbour_imitates;
    logic [WORD_BITS-1:0] traits_word;
    logic [DRAW_BITS-1:0] accept_draw;
    logic [DRAW_BITS-1:0] trait_draw;

    modport source (
        output valid, func, node, vertical_link, neighbour_imitates,
               traits_word, accept_draw, trait_draw,
        input  ready
    );

    modport sink (
        input  valid, func, node, vertical_link, neighbour_imitates,
               traits_word, accept_draw, trait_draw,
        output ready
    );
endinterface

interface axli_rsp_if
    import axli_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [WORD_BITS-1:0]  read_traits;
    logic [SIM_BITS-1:0]   similarity;
    logic                  changed;
    logic [TRAIT_BITS-1:0] changed_trait;

    modport source (
        output valid, read_traits, similarity, changed, changed_trait,
        input  ready
    );

    modport sink (
        input  valid, read_traits, similarity, changed, changed_trait,
        output ready
    );
endinterface

// ===== hw/rtl/axli_mem.sv =====
// axli_mem: node trait store, one write port and one registered read port
// depends on axli_pkg for the word width

module axli_mem
    import axli_pkg::*;
#(
    parameter int DEPTH  = AXLI_SIDE * AXLI_SIDE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/axli_trait_unit.sv =====
// axli_trait_unit: shared shift and compare unit, one trait of two words per use
// depends on axli_pkg for the word width and the result struct

module axli_trait_unit
    import axli_pkg::*;
#(
    parameter int TRAITS     = AXLI_TRAITS,
    parameter int VALUE_BITS = AXLI_VALUE_BITS,
    parameter int J_W        = $clog2(TRAITS)
) (
    input  logic [WORD_BITS-1:0] dst_word,
    input  logic [WORD_BITS-1:0] src_word,
    input  logic [J_W-1:0]       j,
    output axli_cmp_t            cmp
);

    localparam int SH_W = J_W + 4;
    localparam logic [WORD_BITS-1:0] VMASK = WORD_BITS'((32'd1 << VALUE_BITS) - 32'd1);

    logic [SH_W-1:0]       sh;
    logic [WORD_BITS-1:0]  dst_sh;
    logic [WORD_BITS-1:0]  src_sh;
    logic [WORD_BITS-1:0]  mask_sh;
    logic [VALUE_BITS-1:0] a;
    logic [VALUE_BITS-1:0] b;

    always_comb
    begin
        sh         = SH_W'(j) * SH_W'(VALUE_BITS);
        dst_sh     = dst_word >> sh;
        src_sh     = src_word >> sh;
        a          = dst_sh[VALUE_BITS-1:0];
        b          = src_sh[VALUE_BITS-1:0];
        mask_sh    = VMASK << sh;
        cmp.same   = (a == b);
        cmp.merged = (dst_word & ~mask_sh) | (WORD_BITS'(b) << sh);
    end

endmodule

// ===== hw/rtl/axli_nbr.sv =====
// axli_nbr: neighbour index on the periodic lattice, row by reciprocal multiply
// depends on axli_pkg for the node field width

module axli_nbr
    import axli_pkg::*;
#(
    parameter int SIDE   = AXLI_SIDE,
    parameter int NODE_W = $clog2(SIDE * SIDE)
) (
    input  logic                 clk,
    input  logic                 load,
    input  logic [NODE_BITS-1:0] node,
    input  logic                 vertical_link,
    output logic [NODE_W-1:0]    nb
);

    localparam int NODES       = SIDE * SIDE;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + SIDE - 1) / SIDE);

    logic [NODE_BITS+RECIP_W-1:0] prod;
    logic [NODE_BITS-1:0]         q_reg;
    logic [NODE_BITS-1:0]         q_side;
    logic [NODE_BITS-1:0]         col;
    logic                         at_right_edge;
    logic [NODE_W:0]              down;
    logic [NODE_W:0]              right;

    assign prod = (NODE_BITS + RECIP_W)'(node) * (NODE_BITS + RECIP_W)'(RECIP);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= prod[RECIP_SHIFT +: NODE_BITS];
        end
    end

    always_comb
    begin
        q_side        = NODE_BITS'(q_reg * SIDE);
        col           = node - q_side;
        at_right_edge = (col == NODE_BITS'(SIDE - 1));
        down          = (NODE_W + 1)'(node) + (NODE_W + 1)'(SIDE);
        if (down >= (NODE_W + 1)'(NODES))
        begin
            down = down - (NODE_W + 1)'(NODES);
        end
        right = (NODE_W + 1)'(node) + (NODE_W + 1)'(1);
        if (at_right_edge)
        begin
            right = right - (NODE_W + 1)'(SIDE);
        end
        nb = vertical_link ? down[NODE_W-1:0] : right[NODE_W-1:0];
    end

endmodule

// ===== hw/rtl/axelrod_link_interaction_core.sv =====
// axelrod_link_interaction_core: top level, sequencer around the shared trait unit
// depends on axli_pkg, axli_if, axli_mem, axli_trait_unit and axli_nbr
//
//   channel | direction | handshake   | payload
//   req     | in        | valid/ready | func node vertical_link neighbour_imitates
//           |           |             | traits_word accept_draw trait_draw
//   rsp     | out       | valid/ready | read_traits similarity changed changed_trait
//
// the trait unit looks at one trait a cycle: one pass counts, a second picks the trait
// req.ready is high only while the sequencer is idle; rsp has an output register
// a result waiting on rsp.ready holds the sequencer in its last step only
// reset clears the sequencer and rsp.valid; the node store is not cleared

module axelrod_link_interaction_core
    import axli_pkg::*;
#(
    parameter int SIDE       = AXLI_SIDE,
    parameter int TRAITS     = AXLI_TRAITS,
    parameter int VALUE_BITS = AXLI_VALUE_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    axli_req_if.sink   req,
    axli_rsp_if.source rsp
);

    localparam int NODES     = SIDE * SIDE;
    localparam int DEPTH     = (NODES < (1 << NODE_BITS)) ? NODES : (1 << NODE_BITS);
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int NODE_W    = $clog2(NODES);
    localparam int J_W       = $clog2(TRAITS);
    localparam int CNT_W     = $clog2(TRAITS + 1);
    localparam int USED_BITS = (TRAITS * VALUE_BITS < WORD_BITS) ?
                               TRAITS * VALUE_BITS : WORD_BITS;
    localparam logic [WORD_BITS-1:0] USED_MASK = (USED_BITS >= WORD_BITS) ? '1 :
                               WORD_BITS'((32'd1 << USED_BITS) - 32'd1);
    localparam int ACC_W     = DRAW_BITS + CNT_W;

    axli_state_t state_reg;
    axli_state_t state_next;

    logic [1:0]           func_reg;
    logic [NODE_BITS-1:0] node_reg;
    logic                 vert_reg;
    logic                 nimit_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [DRAW_BITS-1:0] adraw_reg;
    logic [DRAW_BITS-1:0] tdraw_reg;

    logic [ADDR_W-1:0]    dst_addr_reg;
    logic [ADDR_W-1:0]    src_addr_reg;
    logic                 dst_ok_reg;
    logic [WORD_BITS-1:0] dst_word_reg;
    logic [WORD_BITS-1:0] src_word_reg;
    logic [WORD_BITS-1:0] rd_word_reg;
    logic [J_W-1:0]       j_reg;
    logic [J_W-1:0]       seen_reg;
    logic [J_W-1:0]       k_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SIM_BITS-1:0]  sim_reg;
    logic                 chg_reg;
    logic [TRAIT_BITS-1:0] ctr_reg;

    logic                  rsp_valid_reg;
    logic [WORD_BITS-1:0]  out_traits_reg;
    logic [SIM_BITS-1:0]   out_sim_reg;
    logic                  out_chg_reg;
    logic [TRAIT_BITS-1:0] out_ctr_reg;

    logic                 accept;
    logic                 in_range;
    logic                 nbr_load;
    logic                 rsp_load;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;
    logic [NODE_W-1:0]    nb;
    logic [ADDR_W-1:0]    node_a;
    logic [ADDR_W-1:0]    nb_a;
    logic                 nb_ok;
    axli_cmp_t            cmp;

    logic [4:0]           cnt5;
    logic [SIM_BITS-1:0]  sim_sat;
    logic [CNT_W-1:0]     differing;
    logic [ACC_W-1:0]     kprod;
    logic [20:0]          acc_lhs;
    logic [20:0]          acc_rhs;
    logic                 link_accept;
    logic                 last_trait;
    logic                 pick;

    axli_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    axli_trait_unit #(
        .TRAITS     (TRAITS),
        .VALUE_BITS (VALUE_BITS),
        .J_W        (J_W)
    ) u_trait (
        .dst_word (dst_word_reg),
        .src_word (src_word_reg),
        .j        (j_reg),
        .cmp      (cmp)
    );

    axli_nbr #(
        .SIDE   (SIDE),
        .NODE_W (NODE_W)
    ) u_nbr (
        .clk           (clk),
        .load          (nbr_load),
        .node          (node_reg),
        .vertical_link (vert_reg),
        .nb            (nb)
    );

    assign accept   = req.valid && req.ready;
    assign in_range = (32'(node_reg) < NODES);
    assign node_a   = node_reg[ADDR_W-1:0];
    assign nb_a     = nb[ADDR_W-1:0];
    assign nb_ok    = (32'(nb) < DEPTH);

    always_comb
    begin
        cnt5        = 5'(cnt_reg);
        sim_sat     = (cnt5 > 5'd15) ? 4'd15 : cnt5[3:0];
        differing   = CNT_W'(TRAITS) - cnt_reg;
        kprod       = ACC_W'(tdraw_reg) * ACC_W'(differing);
        acc_lhs     = 21'(adraw_reg) * 21'(TRAITS);
        acc_rhs     = 21'(cnt_reg) << DRAW_BITS;
        link_accept = (cnt_reg != '0) && (cnt_reg < CNT_W'(TRAITS)) && (acc_lhs < acc_rhs);
        last_trait  = (j_reg == J_W'(TRAITS - 1));
        pick        = !cmp.same && (seen_reg == k_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req.ready  = 1'b0;
        nbr_load   = 1'b0;
        rsp_load   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = dst_addr_reg;
        mem_wdata  = cmp.merged;
        mem_raddr  = src_addr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                nbr_load   = 1'b1;
                state_next = S_NBR;
            end
            S_NBR:
            begin
                state_next = S_DONE;
                if (in_range)
                begin
                    unique case (func_reg) inside
                        FUNC_WRITE:
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = node_a;
                            mem_wdata = word_reg & USED_MASK;
                        end
                        FUNC_READ, FUNC_LINK:
                        begin
                            state_next = S_RD_DST;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RD_DST:
            begin
                mem_raddr  = dst_addr_reg;
                state_next = S_RD_SRC;
            end
            S_RD_SRC:
            begin
                state_next = (func_reg == FUNC_READ) ? S_DONE : S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_COUNT;
            end
            S_COUNT:
            begin
                if (last_trait)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = link_accept ? S_SELECT : S_DONE;
            end
            S_SELECT:
            begin
                if (pick)
                begin
                    mem_we     = dst_ok_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_reg    <= req.func;
                    node_reg    <= req.node;
                    vert_reg    <= req.vertical_link;
                    nimit_reg   <= req.neighbour_imitates;
                    word_reg    <= req.traits_word;
                    adraw_reg   <= req.accept_draw;
                    tdraw_reg   <= req.trait_draw;
                    rd_word_reg <= '0;
                    sim_reg     <= '0;
                    chg_reg     <= 1'b0;
                    ctr_reg     <= '0;
                end
            end
            S_NBR:
            begin
                if (func_reg == FUNC_READ)
                begin
                    dst_addr_reg <= node_a;
                    dst_ok_reg   <= 1'b1;
                end
                else
                begin
                    dst_addr_reg <= nimit_reg ? nb_a : node_a;
                    src_addr_reg <= nimit_reg ? node_a : nb_a;
                    dst_ok_reg   <= nimit_reg ? nb_ok : 1'b1;
                end
            end
            S_RD_SRC:
            begin
                dst_word_reg <= mem_rdata;
                if (func_reg == FUNC_READ)
                begin
                    rd_word_reg <= mem_rdata;
                end
            end
            S_LOAD:
            begin
                src_word_reg <= mem_rdata;
                j_reg        <= '0;
                cnt_reg      <= '0;
            end
            S_COUNT:
            begin
                if (cmp.same)
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                j_reg <= j_reg + J_W'(1);
            end
            S_DECIDE:
            begin
                sim_reg  <= sim_sat;
                k_reg    <= kprod[DRAW_BITS +: J_W];
                j_reg    <= '0;
                seen_reg <= '0;
            end
            S_SELECT:
            begin
                if (pick)
                begin
                    chg_reg <= 1'b1;
                    ctr_reg <= TRAIT_BITS'(j_reg);
                end
                else if (!cmp.same)
                begin
                    seen_reg <= seen_reg + J_W'(1);
                end
                j_reg <= j_reg + J_W'(1);
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    out_traits_reg <= rd_word_reg;
                    out_sim_reg    <= sim_reg;
                    out_chg_reg    <= chg_reg;
                    out_ctr_reg    <= ctr_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.read_traits   = out_traits_reg;
    assign rsp.similarity    = out_sim_reg;
    assign rsp.changed       = out_chg_reg;
    assign rsp.changed_trait = out_ctr_reg;

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("item accepted while previous item in progress");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_NBR || state_reg == S_SELECT))
        else $error("node store written outside write or update step");

    a_select_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SELECT) |-> (32'(j_reg) < TRAITS))
        else $error("trait selection ran past the last trait");

    a_change_sim: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.changed) |->
            (rsp.similarity != '0 && 32'(rsp.similarity) < TRAITS))
        else $error("trait copied on a link outside the accepted similarity range");

    a_nochange_trait: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.changed) |-> (rsp.changed_trait == '0))
        else $error("changed trait index set without a change");
`endif

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for axelrod_link_interaction_core on a periodic lattice
// depends on axli_pkg, axli_req_if, axli_rsp_if and the core; predicts every result
// and checks it field by field against the response channel

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import axli_pkg::*;

    localparam int NODES        = AXLI_SIDE * AXLI_SIDE;
    localparam int VB           = AXLI_VALUE_BITS;
    localparam int USED_BITS    = (AXLI_TRAITS * VB >= WORD_BITS) ? WORD_BITS : AXLI_TRAITS * VB;
    localparam logic [WORD_BITS-1:0] USED_MASK  = {WORD_BITS{1'b1}} >> (WORD_BITS - USED_BITS);
    localparam logic [WORD_BITS-1:0] VALUE_MASK = WORD_BITS'((1 << VB) - 1);
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 900;
    localparam int CALM_ITEMS   = 120;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_AT     = 600;
    localparam int QUIET_LIMIT  = 2000;

    typedef struct {
        logic [1:0]           func;
        logic [NODE_BITS-1:0] node;
        logic                 vert;
        logic                 nimit;
        logic [WORD_BITS-1:0] word;
        logic [DRAW_BITS-1:0] adraw;
        logic [DRAW_BITS-1:0] tdraw;
    } link_req_t;

    typedef struct {
        logic [WORD_BITS-1:0]  rd;
        logic [SIM_BITS-1:0]   sim;
        logic                  chg;
        logic [TRAIT_BITS-1:0] ctr;
    } link_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    axli_req_if req_ch ();
    axli_rsp_if rsp_ch ();

    axelrod_link_interaction_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    link_req_t            pending[$];
    link_rsp_t            link_expect_q[$];
    logic [WORD_BITS-1:0] lattice [NODES];
    bit                   seen_node [NODES];
    int unsigned          live_q[$];

    int        n_items;
    int        err_cnt = 0;
    int        pred_cnt;
    int        done_cnt;
    int        gap_left;
    int        stall_left;
    int        hold_left;
    bit        held;
    int        quiet = 0;
    bit        req_fire;
    int        req_taken;
    link_rsp_t want_rsp;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb_top: result %0d %s got %0h want %0h", done_cnt, what, got, want);
        err_cnt++;
    endtask

    function automatic int unsigned neighbour_of(input int unsigned n, input logic vert);
        int unsigned row;
        int unsigned col;
        row = n / AXLI_SIDE;
        col = n % AXLI_SIDE;
        if (vert)
            return ((row + 1) % AXLI_SIDE) * AXLI_SIDE + col;
        return row * AXLI_SIDE + (col + 1) % AXLI_SIDE;
    endfunction

    function automatic logic [WORD_BITS-1:0] trait_of(input logic [WORD_BITS-1:0] w,
                                                     input int unsigned j);
        int unsigned sh;
        sh = j * VB;
        if (sh >= WORD_BITS)
            return '0;
        return (w >> sh) & VALUE_MASK;
    endfunction

    // one item against the shadow lattice
    function automatic link_rsp_t predict_link(input link_req_t it);
        link_rsp_t            r;
        int unsigned          nb;
        int unsigned          dst;
        int unsigned          src;
        int unsigned          cnt;
        int unsigned          differing;
        int unsigned          k;
        int unsigned          seen;
        int unsigned          sh;
        logic [WORD_BITS-1:0] dw;
        logic [WORD_BITS-1:0] sw;
        r = '{default: '0};
        if (it.node < NODES) begin
            case (it.func)
                FUNC_WRITE: lattice[it.node] = it.word & USED_MASK;
                FUNC_READ:  r.rd = lattice[it.node];
                FUNC_LINK:
                begin
                    nb  = neighbour_of(it.node, it.vert);
                    dst = it.nimit ? nb : it.node;
                    src = it.nimit ? it.node : nb;
                    dw  = lattice[dst];
                    sw  = lattice[src];
                    cnt = 0;
                    for (int unsigned j = 0; j < AXLI_TRAITS; j++)
                        if (trait_of(dw, j) == trait_of(sw, j))
                            cnt++;
                    r.sim = (cnt > 15) ? 4'd15 : SIM_BITS'(cnt);
                    if (cnt > 0 && cnt < AXLI_TRAITS &&
                        (longint'(it.adraw) * AXLI_TRAITS) < (longint'(cnt) << DRAW_BITS))
                    begin
                        differing = AXLI_TRAITS - cnt;
                        k = (int'(it.tdraw) * differing) >> DRAW_BITS;
                        seen = 0;
                        for (int unsigned j = 0; j < AXLI_TRAITS; j++) begin
                            if (trait_of(dw, j) != trait_of(sw, j)) begin
                                if (seen == k) begin
                                    sh = j * VB;
                                    if (sh < WORD_BITS)
                                        dw = (dw & ~(VALUE_MASK << sh)) | (trait_of(sw, j) << sh);
                                    lattice[dst] = dw;
                                    r.chg = 1'b1;
                                    r.ctr = TRAIT_BITS'(j);
                                    break;
                                end
                                seen++;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic add(input logic [1:0] f, input int unsigned n, input logic v,
                       input logic ni, input logic [WORD_BITS-1:0] w,
                       input logic [DRAW_BITS-1:0] a, input logic [DRAW_BITS-1:0] t);
        link_req_t it;
        it.func  = f;
        it.node  = NODE_BITS'(n);
        it.vert  = v;
        it.nimit = ni;
        it.word  = w;
        it.adraw = a;
        it.tdraw = t;
        if (f == FUNC_WRITE && !seen_node[n]) begin
            seen_node[n] = 1'b1;
            live_q.push_back(n);
        end
        pending.push_back(it);
    endtask

    function automatic logic [DRAW_BITS-1:0] rand_draw();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return DRAW_BITS'($urandom());
        endcase
    endfunction

    // mostly near a shared base pattern so that links often agree in part
    function automatic logic [WORD_BITS-1:0] make_word();
        logic [WORD_BITS-1:0] w;
        logic [WORD_BITS-1:0] v;
        if ($urandom_range(0, 2) == 0)
            return WORD_BITS'($urandom());
        w = '0;
        for (int unsigned j = 0; j < AXLI_TRAITS; j++) begin
            if ($urandom_range(0, 3) == 0)
                v = WORD_BITS'($urandom()) & VALUE_MASK;
            else
                v = WORD_BITS'(j) & VALUE_MASK;
            if (j * VB < WORD_BITS)
                w = w | (v << (j * VB));
        end
        return w;
    endfunction

    task automatic add_random_item();
        int unsigned pick;
        int unsigned n;
        int unsigned row;
        int unsigned col;
        logic        vert;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            if ($urandom_range(0, 4) == 0) begin
                n = $urandom_range(0, NODES - 1);
            end else begin
                case ($urandom_range(0, 3))
                    0:       row = 0;
                    1:       row = 1;
                    2:       row = AXLI_SIDE / 2 - 1;
                    default: row = AXLI_SIDE - 1;
                endcase
                case ($urandom_range(0, 4))
                    0:       col = 0;
                    1:       col = 1;
                    2:       col = AXLI_SIDE / 2;
                    3:       col = AXLI_SIDE - 2;
                    default: col = AXLI_SIDE - 1;
                endcase
                n = row * AXLI_SIDE + col;
            end
            add(FUNC_WRITE, n, $urandom_range(0, 1), $urandom_range(0, 1), make_word(),
                rand_draw(), rand_draw());
        end else if (pick < 28) begin
            add(FUNC_READ, live_q[$urandom_range(0, live_q.size() - 1)], $urandom_range(0, 1),
                $urandom_range(0, 1), WORD_BITS'($urandom()), rand_draw(), rand_draw());
        end else if (pick < 32) begin
            add(FUNC_SPARE, $urandom_range(0, NODES - 1), $urandom_range(0, 1),
                $urandom_range(0, 1), WORD_BITS'($urandom()), rand_draw(), rand_draw());
        end else begin
            n = live_q[$urandom_range(0, live_q.size() - 1)];
            vert = $urandom_range(0, 1);
            if (!seen_node[neighbour_of(n, vert)])
                vert = !vert;
            if (!seen_node[neighbour_of(n, vert)])
                add(FUNC_WRITE, neighbour_of(n, vert), $urandom_range(0, 1),
                    $urandom_range(0, 1), make_word(), rand_draw(), rand_draw());
            else
                add(FUNC_LINK, n, vert, $urandom_range(0, 1), WORD_BITS'($urandom()),
                    rand_draw(), rand_draw());
        end
    endtask

    // request driver, also runs the predictor on every accepted item
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_ch.valid              <= 1'b0;
            req_ch.func               <= '0;
            req_ch.node               <= '0;
            req_ch.vertical_link      <= 1'b0;
            req_ch.neighbour_imitates <= 1'b0;
            req_ch.traits_word        <= '0;
            req_ch.accept_draw        <= '0;
            req_ch.trait_draw         <= '0;
            gap_left                  <= 0;
            pred_cnt                  <= 0;
        end else begin
            req_fire = req_ch.valid && req_ch.ready;
            if (req_fire)
                link_expect_q.push_back(predict_link(pending.pop_front()));
            req_taken = pred_cnt + (req_fire ? 1 : 0);
            pred_cnt <= req_taken;
            if (req_ch.valid && !req_ch.ready) begin
                // item still on offer
            end else if (gap_left > 0) begin
                gap_left     <= gap_left - 1;
                req_ch.valid <= 1'b0;
            end else if (pending.size() == 0 || (req_taken == DRAIN_AT && done_cnt != DRAIN_AT))
            begin
                req_ch.valid <= 1'b0;
            end else if (req_taken < n_items - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                gap_left     <= $urandom_range(0, 10);
                req_ch.valid <= 1'b0;
            end else begin
                req_ch.valid              <= 1'b1;
                req_ch.func               <= pending[0].func;
                req_ch.node               <= pending[0].node;
                req_ch.vertical_link      <= pending[0].vert;
                req_ch.neighbour_imitates <= pending[0].nimit;
                req_ch.traits_word        <= pending[0].word;
                req_ch.accept_draw        <= pending[0].adraw;
                req_ch.trait_draw         <= pending[0].tdraw;
            end
        end
    end

    // response monitor and ready generation
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            held         <= 1'b0;
            done_cnt     <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                done_cnt <= done_cnt + 1;
                if (link_expect_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want_rsp = link_expect_q.pop_front();
                    if (rsp_ch.read_traits !== want_rsp.rd)
                        report_mismatch("read_traits", 32'(rsp_ch.read_traits),
                                        32'(want_rsp.rd));
                    if (rsp_ch.similarity !== want_rsp.sim)
                        report_mismatch("similarity", 32'(rsp_ch.similarity),
                                        32'(want_rsp.sim));
                    if (rsp_ch.changed !== want_rsp.chg)
                        report_mismatch("changed", 32'(rsp_ch.changed), 32'(want_rsp.chg));
                    if (rsp_ch.changed_trait !== want_rsp.ctr)
                        report_mismatch("changed_trait", 32'(rsp_ch.changed_trait),
                                        32'(want_rsp.ctr));
                end
            end
            if (!held && pred_cnt >= HOLD_AT) begin
                held         <= 1'b1;
                hold_left    <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end else if (pred_cnt < n_items - CALM_ITEMS && $urandom_range(0, 7) == 0) begin
                stall_left   <= $urandom_range(0, 10);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("tb_top: done, errors");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        rst_n = 1'b0;

        // field extremes; both link directions, wrap at both edges further on
        add(FUNC_WRITE, 0, 0, 0, '0, 0, 0);
        add(FUNC_WRITE, 1, 0, 0, '1, 0, 0);
        add(FUNC_READ, 0, 0, 0, '1, '1, '1);
        add(FUNC_READ, 1, 1, 1, '0, 0, 0);
        // no shared trait, never accepted
        add(FUNC_LINK, 0, 0, 0, 0, 0, 0);
        add(FUNC_WRITE, 1, 0, 0, 30'h7, 0, 0);
        // one differing trait, draw too high, then accepted
        add(FUNC_LINK, 0, 0, 1, 0, 16'hFFFF, 0);
        add(FUNC_LINK, 0, 0, 0, 0, 0, 16'hFFFF);
        // all traits shared, nothing to copy
        add(FUNC_LINK, 0, 0, 0, 0, 0, 0);
        add(FUNC_WRITE, AXLI_SIDE - 1, 0, 0, 30'h15555555, 0, 0);
        add(FUNC_LINK, AXLI_SIDE - 1, 0, 1, 0, 0, 16'hFFFF);
        add(FUNC_WRITE, NODES - AXLI_SIDE, 0, 0, 30'h3FFFFFF8, 0, 0);
        add(FUNC_LINK, NODES - AXLI_SIDE, 1, 0, 0, 0, 0);
        add(FUNC_WRITE, NODES - 1, 0, 0, 30'h12345678, 0, 0);
        add(FUNC_LINK, NODES - 1, 0, 1, 0, 16'h7FFF, 16'h8000);
        add(FUNC_LINK, NODES - 1, 1, 0, 0, 1, 1);
        add(FUNC_READ, NODES - 1, 0, 0, 0, 0, 0);
        add(FUNC_SPARE, NODES - 1, 1, 1, '1, '1, '1);
        add(FUNC_READ, 0, 0, 0, 0, 0, 0);
        add(FUNC_READ, NODES - AXLI_SIDE, 0, 0, 0, 0, 0);
        add(FUNC_READ, AXLI_SIDE - 1, 0, 0, 0, 0, 0);

        repeat (RANDOM_ITEMS)
            add_random_item();
        n_items = pending.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (done_cnt != n_items)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (link_expect_q.size() != 0)
            report_mismatch("expectations left over", link_expect_q.size(), 0);
        if (err_cnt == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule
